// ----- sv/elc_pkg.sv -----
`timescale 1ns / 1ps

package elc_pkg;

    // Default sizes
    localparam int NUM_STATES_DEF = 4;
    localparam int NUM_MEAS_DEF   = 2;
    localparam int NUM_OUT_DEF    = 2;
    localparam int CT_LEN_DEF     = 256;
    localparam int Q_BITS_DEF     = 32;
    localparam int DIGIT_BITS_DEF = 8;

    // Address width carried between sequencer and memories (covers the largest store)
    localparam int CTL_AW = 16;
    // Digit shift width (modulus is at most 64 bits)
    localparam int SH_W   = 6;

    // Command codes
    localparam logic [3:0] CMD_LD_OCOEF = 4'd0;
    localparam logic [3:0] CMD_LD_SCOEF = 4'd1;
    localparam logic [3:0] CMD_LD_STATE = 4'd2;
    localparam logic [3:0] CMD_LD_MEAS  = 4'd3;
    localparam logic [3:0] CMD_COMPUTE  = 4'd4;
    localparam logic [3:0] CMD_LD_FB    = 4'd5;
    localparam logic [3:0] CMD_UPDATE   = 4'd6;
    localparam logic [3:0] CMD_RD_OUT   = 4'd7;
    localparam logic [3:0] CMD_RD_STATE = 4'd8;

    // Sequencer controls toward the memories and the MAC unit
    typedef struct packed {
        logic              idle;
        logic              rd_done;
        logic              cp_rd;
        logic [CTL_AW-1:0] cp_addr;
        logic              upd;
        logic [CTL_AW-1:0] coef_addr;
        logic [CTL_AW-1:0] word_addr;
        logic              word_fb;
        logic [SH_W-1:0]   sh;
        logic              mul_en;
        logic              acc_en;
        logic              clr;
        logic              wb;
        logic [CTL_AW-1:0] wb_addr;
    } t_seq_ctl;

endpackage

// ----- sv/elc_mac.sv -----
`timescale 1ns / 1ps

module elc_mac #(
    parameter int DIGIT_BITS = elc_pkg::DIGIT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  elc_pkg::t_seq_ctl       i_ctl,
    input  logic [31:0]             i_coef,
    input  logic [31:0]             i_word,
    output logic [31:0]             o_acc
);

    localparam logic [31:0] DMASK = (DIGIT_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << DIGIT_BITS) - 64'd1);

    logic [31:0] w_digit;
    logic [63:0] w_prod;
    logic [31:0] r_prod;
    logic [31:0] r_acc;

    // Extract the current digit of the word
    always_comb begin
        if (32'(i_ctl.sh) >= 32'd32) begin
            w_digit = 32'd0;
        end else begin
            w_digit = (i_word >> i_ctl.sh) & DMASK;
        end
        w_prod = 64'(i_coef) * 64'(w_digit);
    end

    // Register the product
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod[31:0];
        end
    end

    // Accumulate modulo 2^32
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 32'd0;
        end else if (i_ctl.clr) begin
            r_acc <= 32'd0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- sv/elc_seq.sv -----
`timescale 1ns / 1ps

module elc_seq #(
    parameter int NUM_STATES = elc_pkg::NUM_STATES_DEF,
    parameter int NUM_MEAS   = elc_pkg::NUM_MEAS_DEF,
    parameter int NUM_OUT    = elc_pkg::NUM_OUT_DEF,
    parameter int CT_LEN     = elc_pkg::CT_LEN_DEF,
    parameter int Q_BITS     = elc_pkg::Q_BITS_DEF,
    parameter int DIGIT_BITS = elc_pkg::DIGIT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start_out,
    input  logic              i_start_upd,
    input  logic              i_start_rd,
    output elc_pkg::t_seq_ctl o_ctl
);

    localparam int NDIG  = (Q_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int XY    = NUM_STATES + NUM_MEAS;
    localparam int XYU   = XY + NUM_OUT;
    localparam int OUT_K = NDIG * XY;
    localparam int ST_K  = NDIG * XYU;
    localparam int AW    = elc_pkg::CTL_AW;
    localparam int SW    = elc_pkg::SH_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_COPY  = 7'b0000100,
        S_ISSUE = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_ACC   = 7'b0100000,
        S_WB    = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic          r_upd;
    logic [AW-1:0] r_cp;
    logic [4:0]    r_i;
    logic [7:0]    r_j;
    logic [4:0]    r_r;
    logic [AW-1:0] r_k;
    logic [SW-1:0] r_sh;
    logic [AW-1:0] r_cbase;
    logic [AW-1:0] r_rbase;
    logic [AW-1:0] r_ibase;

    logic w_k_last, w_r_last, w_i_last, w_j_last, w_cp_last, w_fb;

    // Loop limits
    always_comb begin
        w_k_last  = r_upd ? (r_k == AW'(ST_K - 1)) : (r_k == AW'(OUT_K - 1));
        w_r_last  = r_upd ? (r_r == 5'(XYU - 1)) : (r_r == 5'(XY - 1));
        w_i_last  = r_upd ? (r_i == 5'(NUM_STATES - 1)) : (r_i == 5'(NUM_OUT - 1));
        w_j_last  = (r_j == 8'(CT_LEN - 1));
        w_cp_last = (r_cp == AW'(XY * CT_LEN - 1));
        w_fb      = (r_r >= 5'(XY));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start_out) begin
                    n_state = S_COPY;
                end else if (i_start_upd) begin
                    n_state = S_ISSUE;
                end else if (i_start_rd) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_IDLE;
            S_COPY:  n_state = w_cp_last ? S_ISSUE : S_COPY;
            S_ISSUE: n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = w_k_last ? S_WB : S_ISSUE;
            S_WB:    n_state = (w_j_last && w_i_last) ? S_IDLE : S_ISSUE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd   <= 1'b0;
            r_cp    <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_r     <= '0;
            r_k     <= '0;
            r_sh    <= '0;
            r_cbase <= '0;
            r_rbase <= '0;
            r_ibase <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_upd   <= i_start_upd;
                    r_cp    <= '0;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_r     <= '0;
                    r_k     <= '0;
                    r_sh    <= '0;
                    r_cbase <= '0;
                    r_rbase <= '0;
                    r_ibase <= '0;
                end
                S_COPY: begin
                    r_cp <= r_cp + AW'(1);
                end
                S_ACC: begin
                    if (!w_k_last) begin
                        r_k <= r_k + AW'(1);
                        if (w_r_last) begin
                            r_r     <= '0;
                            r_rbase <= '0;
                            r_sh    <= r_sh + SW'(DIGIT_BITS);
                        end else begin
                            r_r     <= r_r + 5'd1;
                            r_rbase <= r_rbase + AW'(CT_LEN);
                        end
                    end
                end
                S_WB: begin
                    r_k     <= '0;
                    r_r     <= '0;
                    r_rbase <= '0;
                    r_sh    <= '0;
                    if (w_j_last) begin
                        r_j     <= '0;
                        r_i     <= r_i + 5'd1;
                        r_cbase <= r_cbase + (r_upd ? AW'(ST_K) : AW'(OUT_K));
                        r_ibase <= r_ibase + AW'(CT_LEN);
                    end else begin
                        r_j <= r_j + 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Drive controls
    always_comb begin
        o_ctl.idle      = (r_state == S_IDLE);
        o_ctl.rd_done   = (r_state == S_READ);
        o_ctl.cp_rd     = (r_state == S_COPY);
        o_ctl.cp_addr   = r_cp;
        o_ctl.upd       = r_upd;
        o_ctl.coef_addr = r_cbase + r_k;
        o_ctl.word_fb   = w_fb;
        o_ctl.word_addr = w_fb ? (r_rbase - AW'(XY * CT_LEN) + AW'(r_j)) : (r_rbase + AW'(r_j));
        o_ctl.sh        = r_sh;
        o_ctl.mul_en    = (r_state == S_MUL);
        o_ctl.acc_en    = (r_state == S_ACC);
        o_ctl.clr       = (r_state == S_WB) || (r_state == S_IDLE);
        o_ctl.wb        = (r_state == S_WB);
        o_ctl.wb_addr   = r_ibase + AW'(r_j);
    end

endmodule

// ----- sv/encrypted_linear_controller_step.sv -----
`timescale 1ns / 1ps

// Encrypted linear controller over ciphertext rows modulo 2^Q_BITS.
// Input channel: i_valid / o_ready with i_cmd, i_row, i_col, i_value.
// Output channel: o_valid / i_ready with o_value_res, o_status; one result per item.
// Load, compute and update items put their result in the output register at acceptance;
// it is visible the next cycle. Read items register the memory word before the result register takes it.
// Compute first snapshots state and measurement, then forms NUM_OUT*CT_LEN output words
// of OUT_K products each; update forms NUM_STATES*CT_LEN state words of ST_K products,
// where XY = NUM_STATES+NUM_MEAS, OUT_K = NDIG*XY, ST_K = NDIG*(XY+NUM_OUT)
// and NDIG = ceil(Q_BITS/DIGIT_BITS). Each multiply-accumulate passes through the single
// shared MAC unit in three steps: memory read, multiply, accumulate.
// o_ready is low while a compute or update runs or a read is pending.
// A stalled receiver holds the result; a new item is taken once the result leaves.
// Reset clears the sequencer, the output valid and the snapshot flag; the stores
// hold arbitrary data until written, and the snapshot reads as zero until a compute.
module encrypted_linear_controller_step #(
    parameter int NUM_STATES = elc_pkg::NUM_STATES_DEF,
    parameter int NUM_MEAS   = elc_pkg::NUM_MEAS_DEF,
    parameter int NUM_OUT    = elc_pkg::NUM_OUT_DEF,
    parameter int CT_LEN     = elc_pkg::CT_LEN_DEF,
    parameter int Q_BITS     = elc_pkg::Q_BITS_DEF,
    parameter int DIGIT_BITS = elc_pkg::DIGIT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_cmd,
    input  logic [4:0]  i_row,
    input  logic [7:0]  i_col,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value_res,
    output logic        o_status
);

    localparam int NDIG  = (Q_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int XY    = NUM_STATES + NUM_MEAS;
    localparam int XYU   = XY + NUM_OUT;
    localparam int OUT_K = NDIG * XY;
    localparam int ST_K  = NDIG * XYU;

    localparam int D_OC  = NUM_OUT * OUT_K;
    localparam int D_SC  = NUM_STATES * ST_K;
    localparam int D_CS  = NUM_STATES * CT_LEN;
    localparam int D_MS  = NUM_MEAS * CT_LEN;
    localparam int D_OB  = NUM_OUT * CT_LEN;
    localparam int D_SN  = XY * CT_LEN;

    localparam int A_OC  = $clog2(D_OC);
    localparam int A_SC  = $clog2(D_SC);
    localparam int A_CS  = $clog2(D_CS);
    localparam int A_MS  = $clog2(D_MS);
    localparam int A_OB  = $clog2(D_OB);
    localparam int A_SN  = $clog2(D_SN);

    localparam logic [31:0] QMASK = (Q_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << Q_BITS) - 64'd1);

    elc_pkg::t_seq_ctl w_ctl;

    logic [31:0] m_oc [D_OC];
    logic [31:0] m_sc [D_SC];
    logic [31:0] m_cs [D_CS];
    logic [31:0] m_ms [D_MS];
    logic [31:0] m_fb [D_OB];
    logic [31:0] m_ob [D_OB];
    logic [31:0] m_sn [D_SN];

    logic [31:0] r_oc_q, r_sc_q, r_cs_q, r_ms_q, r_fb_q, r_ob_q, r_sn_q;

    logic        w_acc;
    logic        w_bad;
    logic        w_is_rd;
    logic        w_rd_go;
    logic [31:0] w_oc_a, w_sc_a, w_cs_a, w_ms_a, w_ob_a;
    logic        w_oc_ok, w_sc_ok, w_cs_ok, w_ms_ok, w_ob_ok;
    logic [31:0] w_coef, w_word, w_acc_val, w_wb_val;

    logic        r_snap_valid;
    logic        r_rd_state;
    logic        r_cp_wr;
    logic        r_cp_meas;
    logic [A_SN-1:0] r_cp_idx;
    logic        r_word_fb;
    logic        r_ov;
    logic [31:0] r_val;
    logic        r_st;

    // Decode the transaction: flat addresses and range checks
    always_comb begin
        w_oc_a  = 32'(i_row) * 32'(OUT_K) + 32'(i_col);
        w_sc_a  = 32'(i_row) * 32'(ST_K) + 32'(i_col);
        w_cs_a  = 32'(i_row) * 32'(CT_LEN) + 32'(i_col);
        w_ms_a  = w_cs_a;
        w_ob_a  = w_cs_a;
        w_oc_ok = (32'(i_row) < 32'(NUM_OUT)) && (32'(i_col) < 32'(OUT_K));
        w_sc_ok = (32'(i_row) < 32'(NUM_STATES)) && (32'(i_col) < 32'(ST_K));
        w_cs_ok = (32'(i_row) < 32'(NUM_STATES)) && (32'(i_col) < 32'(CT_LEN));
        w_ms_ok = (32'(i_row) < 32'(NUM_MEAS)) && (32'(i_col) < 32'(CT_LEN));
        w_ob_ok = (32'(i_row) < 32'(NUM_OUT)) && (32'(i_col) < 32'(CT_LEN));
        w_is_rd = 1'b0;
        case (i_cmd)
            elc_pkg::CMD_LD_OCOEF: w_bad = !w_oc_ok;
            elc_pkg::CMD_LD_SCOEF: w_bad = !w_sc_ok;
            elc_pkg::CMD_LD_STATE: w_bad = !w_cs_ok;
            elc_pkg::CMD_LD_MEAS:  w_bad = !w_ms_ok;
            elc_pkg::CMD_LD_FB:    w_bad = !w_ob_ok;
            elc_pkg::CMD_RD_OUT: begin
                w_bad   = !w_ob_ok;
                w_is_rd = 1'b1;
            end
            elc_pkg::CMD_RD_STATE: begin
                w_bad   = !w_cs_ok;
                w_is_rd = 1'b1;
            end
            default: w_bad = 1'b0;
        endcase
        w_acc   = i_valid && o_ready;
        w_rd_go = w_acc && w_is_rd && !w_bad;
    end

    assign o_ready = w_ctl.idle && (!r_ov || i_ready);

    // Sequencer
    elc_seq #(
        .NUM_STATES (NUM_STATES),
        .NUM_MEAS   (NUM_MEAS),
        .NUM_OUT    (NUM_OUT),
        .CT_LEN     (CT_LEN),
        .Q_BITS     (Q_BITS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_out (w_acc && (i_cmd == elc_pkg::CMD_COMPUTE)),
        .i_start_upd (w_acc && (i_cmd == elc_pkg::CMD_UPDATE)),
        .i_start_rd  (w_rd_go),
        .o_ctl       (w_ctl)
    );

    // Select MAC operands from registered memory data
    always_comb begin
        w_coef = w_ctl.upd ? r_sc_q : r_oc_q;
        if (r_word_fb) begin
            w_word = r_fb_q;
        end else begin
            w_word = r_snap_valid ? r_sn_q : 32'd0;
        end
        w_wb_val = w_acc_val & QMASK;
    end

    // Shared multiply-accumulate unit
    elc_mac #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coef  (w_coef),
        .i_word  (w_word),
        .o_acc   (w_acc_val)
    );

    // Output coefficient memory
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_cmd == elc_pkg::CMD_LD_OCOEF) && w_oc_ok) begin
            m_oc[w_oc_a[A_OC-1:0]] <= i_value;
        end
        r_oc_q <= m_oc[w_ctl.coef_addr[A_OC-1:0]];
    end

    // State coefficient memory
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_cmd == elc_pkg::CMD_LD_SCOEF) && w_sc_ok) begin
            m_sc[w_sc_a[A_SC-1:0]] <= i_value;
        end
        r_sc_q <= m_sc[w_ctl.coef_addr[A_SC-1:0]];
    end

    // Controller state memory: loads, update write-back, reads and snapshot sweep
    always_ff @(posedge i_clk) begin
        if (w_ctl.wb && w_ctl.upd) begin
            m_cs[w_ctl.wb_addr[A_CS-1:0]] <= w_wb_val;
        end else if (w_acc && (i_cmd == elc_pkg::CMD_LD_STATE) && w_cs_ok) begin
            m_cs[w_cs_a[A_CS-1:0]] <= i_value;
        end
        if (w_ctl.idle) begin
            r_cs_q <= m_cs[w_cs_a[A_CS-1:0]];
        end else begin
            r_cs_q <= m_cs[w_ctl.cp_addr[A_CS-1:0]];
        end
    end

    // Measurement memory
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_cmd == elc_pkg::CMD_LD_MEAS) && w_ms_ok) begin
            m_ms[w_ms_a[A_MS-1:0]] <= i_value;
        end
        r_ms_q <= m_ms[A_MS'(w_ctl.cp_addr - elc_pkg::CTL_AW'(D_CS))];
    end

    // Feedback memory
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_cmd == elc_pkg::CMD_LD_FB) && w_ob_ok) begin
            m_fb[w_ob_a[A_OB-1:0]] <= i_value;
        end
        r_fb_q <= m_fb[w_ctl.word_addr[A_OB-1:0]];
    end

    // Output ciphertext memory
    always_ff @(posedge i_clk) begin
        if (w_ctl.wb && !w_ctl.upd) begin
            m_ob[w_ctl.wb_addr[A_OB-1:0]] <= w_wb_val;
        end
        r_ob_q <= m_ob[w_ob_a[A_OB-1:0]];
    end

    // Snapshot memory, filled in the cycle after each sweep read
    always_ff @(posedge i_clk) begin
        if (r_cp_wr) begin
            m_sn[r_cp_idx] <= r_cp_meas ? r_ms_q : r_cs_q;
        end
        r_sn_q <= m_sn[w_ctl.word_addr[A_SN-1:0]];
    end

    // Delay the sweep and operand select to line up with the registered memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_wr      <= 1'b0;
            r_snap_valid <= 1'b0;
        end else begin
            r_cp_wr <= w_ctl.cp_rd;
            if (w_acc && (i_cmd == elc_pkg::CMD_COMPUTE)) begin
                r_snap_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_idx  <= w_ctl.cp_addr[A_SN-1:0];
        r_cp_meas <= (w_ctl.cp_addr >= elc_pkg::CTL_AW'(D_CS));
        r_word_fb <= w_ctl.word_fb;
        if (w_acc) begin
            r_rd_state <= (i_cmd == elc_pkg::CMD_RD_STATE);
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_acc && !w_rd_go) begin
            r_ov <= 1'b1;
        end else if (w_ctl.rd_done) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_rd_go) begin
            r_val <= 32'd0;
            r_st  <= w_bad;
        end else if (w_ctl.rd_done) begin
            r_val <= r_rd_state ? r_cs_q : r_ob_q;
            r_st  <= 1'b0;
        end
    end

    assign o_valid     = r_ov;
    assign o_value_res = r_val;
    assign o_status    = r_st;

    // Non-read transactions return a zero word
    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_is_rd) |=> (o_valid && (o_value_res == 32'd0)))
        else $error("non-read result carries data");

    // An in-range read delivers its word the cycle after the memory read
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_go |=> ##1 (o_valid && !o_status))
        else $error("read result missing");

    // Snapshot is filled only after a compute was taken
    a_snap_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_wr |-> r_snap_valid)
        else $error("snapshot written without compute");

    // Write-back never happens while the block takes transactions
    a_wb_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.wb |-> !o_ready)
        else $error("write-back while ready");

endmodule

// ----- tb/sv/encrypted_linear_controller_step_checker.sv -----
`timescale 1ns / 1ps

module encrypted_linear_controller_step_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [3:0]  i_cmd,
    input  logic [4:0]  i_row,
    input  logic [7:0]  i_col,
    input  logic [31:0] i_value,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_value_res,
    input  logic        i_status,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NST   = elc_pkg::NUM_STATES_DEF;
    localparam int NMS   = elc_pkg::NUM_MEAS_DEF;
    localparam int NOU   = elc_pkg::NUM_OUT_DEF;
    localparam int CTL   = elc_pkg::CT_LEN_DEF;
    localparam int QB    = elc_pkg::Q_BITS_DEF;
    localparam int DB    = elc_pkg::DIGIT_BITS_DEF;
    localparam int NDIG  = (QB + DB - 1) / DB;
    localparam int XY    = NST + NMS;
    localparam int XYU   = XY + NOU;
    localparam int OUT_K = NDIG * XY;
    localparam int ST_K  = NDIG * XYU;

    typedef struct packed {
        logic [31:0] word;
        logic        status;
    } t_ctl_result;

    logic [31:0] out_coef   [NOU*OUT_K];
    logic [31:0] state_coef [NST*ST_K];
    logic [31:0] ctrl_state [NST*CTL];
    logic [31:0] meas_buf   [NMS*CTL];
    logic [31:0] fb_buf     [NOU*CTL];
    logic [31:0] out_buf    [NOU*CTL];
    logic [31:0] xy_snap    [XY*CTL];

    t_ctl_result result_fifo[$];
    int          fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = result_fifo.size();

    // Extract digit p of a word, lowest digit first
    function automatic logic [63:0] digit_at(logic [31:0] w, int p);
        int          sh;
        logic [63:0] dm;
        sh = p * DB;
        dm = ((64'd1 << (DB - 1)) << 1) - 64'd1;
        if (sh >= 64) return 64'd0;
        return ({32'd0, w} >> sh) & dm;
    endfunction

    function automatic logic [31:0] mod_q(logic [63:0] acc);
        logic [63:0] qm;
        qm = ((64'd1 << (QB - 1)) << 1) - 64'd1;
        return 32'(acc & qm);
    endfunction

    // Snapshot state over measurement, then multiply by output coefficients
    function automatic void run_compute();
        logic [63:0] acc;
        for (int k = 0; k < NST*CTL; k++) xy_snap[k] = ctrl_state[k];
        for (int k = 0; k < NMS*CTL; k++) xy_snap[NST*CTL+k] = meas_buf[k];
        for (int i = 0; i < NOU; i++)
            for (int j = 0; j < CTL; j++) begin
                acc = 0;
                for (int k = 0; k < OUT_K; k++)
                    acc += 64'(out_coef[i*OUT_K+k]) * digit_at(xy_snap[(k%XY)*CTL+j], k/XY);
                out_buf[i*CTL+j] = mod_q(acc);
            end
    endfunction

    // New state from snapshot stacked over feedback
    function automatic void run_update();
        logic [63:0] acc;
        logic [31:0] w;
        int          r;
        for (int i = 0; i < NST; i++)
            for (int j = 0; j < CTL; j++) begin
                acc = 0;
                for (int k = 0; k < ST_K; k++) begin
                    r = k % XYU;
                    w = (r < XY) ? xy_snap[r*CTL+j] : fb_buf[(r-XY)*CTL+j];
                    acc += 64'(state_coef[i*ST_K+k]) * digit_at(w, k/XYU);
                end
                ctrl_state[i*CTL+j] = mod_q(acc);
            end
    endfunction

    function automatic t_ctl_result predict_result(logic [3:0] cmd, int row, int col,
                                                   logic [31:0] val);
        t_ctl_result res;
        res = '0;
        case (cmd)
            elc_pkg::CMD_LD_OCOEF:
                if (row < NOU && col < OUT_K) out_coef[row*OUT_K+col] = val;
                else res.status = 1'b1;
            elc_pkg::CMD_LD_SCOEF:
                if (row < NST && col < ST_K) state_coef[row*ST_K+col] = val;
                else res.status = 1'b1;
            elc_pkg::CMD_LD_STATE:
                if (row < NST && col < CTL) ctrl_state[row*CTL+col] = val;
                else res.status = 1'b1;
            elc_pkg::CMD_LD_MEAS:
                if (row < NMS && col < CTL) meas_buf[row*CTL+col] = val;
                else res.status = 1'b1;
            elc_pkg::CMD_LD_FB:
                if (row < NOU && col < CTL) fb_buf[row*CTL+col] = val;
                else res.status = 1'b1;
            elc_pkg::CMD_RD_OUT:
                if (row < NOU && col < CTL) res.word = out_buf[row*CTL+col];
                else res.status = 1'b1;
            elc_pkg::CMD_RD_STATE:
                if (row < NST && col < CTL) res.word = ctrl_state[row*CTL+col];
                else res.status = 1'b1;
            elc_pkg::CMD_COMPUTE: run_compute();
            elc_pkg::CMD_UPDATE:  run_update();
            default: ;
        endcase
        return res;
    endfunction

    // Predict on accepted commands, compare on accepted results
    always @(posedge i_clk) begin
        t_ctl_result want;
        if (!i_rst_n) begin
            result_fifo.delete();
            for (int k = 0; k < XY*CTL; k++) xy_snap[k] = '0;
        end else begin
            if (i_valid && i_ready_in)
                result_fifo.push_back(predict_result(i_cmd, i_row, i_col, i_value));
            if (i_res_valid && i_res_ready) begin
                if (result_fifo.size() == 0) begin
                    $error("result with no transaction pending: value_res=%h status=%0d",
                           i_value_res, i_status);
                    fails++;
                end else begin
                    want = result_fifo.pop_front();
                    if (i_value_res !== want.word) begin
                        $error("value_res: expected %h, got %h", want.word, i_value_res);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_encrypted_linear_controller_step.sv -----
`timescale 1ns / 1ps

module tb_encrypted_linear_controller_step;

    localparam int NST      = elc_pkg::NUM_STATES_DEF;
    localparam int NMS      = elc_pkg::NUM_MEAS_DEF;
    localparam int NOU      = elc_pkg::NUM_OUT_DEF;
    localparam int CTL      = elc_pkg::CT_LEN_DEF;
    localparam int NDIG     = (elc_pkg::Q_BITS_DEF + elc_pkg::DIGIT_BITS_DEF - 1) /
                              elc_pkg::DIGIT_BITS_DEF;
    localparam int OUT_K    = NDIG * (NST + NMS);
    localparam int ST_K     = NDIG * (NST + NMS + NOU);
    localparam int N_RANDOM = 550;
    localparam int IDLE_LIMIT = 500000;
    localparam logic [3:0] CMD_UNKNOWN_LO = elc_pkg::CMD_RD_STATE + 4'd1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_cmd = '0;
    logic [4:0]  i_row = '0;
    logic [7:0]  i_col = '0;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_value_res;
    logic        o_status;
    logic        stall_request = 1'b0;
    int          fail_count;
    int          pending;

    encrypted_linear_controller_step DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_row(i_row), .i_col(i_col), .i_value(i_value),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_value_res(o_value_res), .o_status(o_status)
    );

    encrypted_linear_controller_step_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready),
        .i_cmd(i_cmd), .i_row(i_row), .i_col(i_col), .i_value(i_value),
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_value_res(o_value_res), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Mostly no gap, sometimes short, occasionally long; one long hold when requested
    initial begin
        bit held;
        int gap;
        held = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (stall_request && !held) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            case ($urandom_range(0, 9))
                0, 1:    gap = $urandom_range(1, 3);
                2:       gap = $urandom_range(10, 40);
                default: gap = 0;
            endcase
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Idle watchdog
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("tb_encrypted_linear_controller_step NOT OK");
                $finish;
            end
        end
    end

    function automatic void store_dims(logic [3:0] cmd, output int nr, output int nc);
        nc = CTL;
        case (cmd)
            elc_pkg::CMD_LD_OCOEF: begin nr = NOU; nc = OUT_K; end
            elc_pkg::CMD_LD_SCOEF: begin nr = NST; nc = ST_K; end
            elc_pkg::CMD_LD_MEAS:  nr = NMS;
            elc_pkg::CMD_LD_FB, elc_pkg::CMD_RD_OUT: nr = NOU;
            default:      nr = NST;
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Offer one transaction, optional random gap first; hold until accepted
    task automatic send_item(logic [3:0] cmd, int row, int col, logic [31:0] val, bit gaps);
        int gap;
        gap = 0;
        if (gaps)
            case ($urandom_range(0, 9))
                0, 1, 2: gap = $urandom_range(1, 3);
                3:       gap = $urandom_range(8, 30);
                default: gap = 0;
            endcase
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd   <= cmd;
        i_row   <= 5'(row);
        i_col   <= 8'(col);
        i_value <= val;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic fill_store(logic [3:0] cmd);
        int nr, nc;
        store_dims(cmd, nr, nc);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                send_item(cmd, r, c, rand_word(), ($urandom_range(0, 15) == 0));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // In-range or out-of-range address for a store
    task automatic send_addressed(logic [3:0] cmd, bit bad);
        int nr, nc;
        store_dims(cmd, nr, nc);
        if (!bad)
            send_item(cmd, $urandom_range(0, nr-1), $urandom_range(0, nc-1), rand_word(), 1);
        else if ($urandom_range(0, 1))
            send_item(cmd, $urandom_range(nr, 31), $urandom_range(0, 255), rand_word(), 1);
        else
            send_item(cmd, $urandom_range(0, 31), $urandom_range(nc, 255), rand_word(), 1);
    endtask

    initial begin
        logic [3:0] load_cmds[5];
        int         n_heavy;
        load_cmds = '{elc_pkg::CMD_LD_OCOEF, elc_pkg::CMD_LD_SCOEF, elc_pkg::CMD_LD_STATE,
                      elc_pkg::CMD_LD_MEAS, elc_pkg::CMD_LD_FB};
        n_heavy = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out-of-range addresses, field extremes and unknown commands
        send_item(elc_pkg::CMD_LD_OCOEF, 31, 255, 32'hFFFF_FFFF, 0);
        send_item(elc_pkg::CMD_LD_SCOEF, 0, ST_K, 32'h0, 0);
        send_item(elc_pkg::CMD_LD_STATE, NST, 0, 32'hA5A5_5A5A, 1);
        send_item(elc_pkg::CMD_LD_MEAS, NMS, 255, 32'h1, 1);
        send_item(elc_pkg::CMD_LD_FB, 31, 0, 32'h8000_0000, 1);
        send_item(elc_pkg::CMD_RD_OUT, NOU, 3, 32'h0, 1);
        send_item(elc_pkg::CMD_RD_STATE, NST, 255, 32'hFFFF_FFFF, 1);
        send_item(elc_pkg::CMD_RD_STATE, 31, 255, 32'h0, 1);
        send_item(CMD_UNKNOWN_LO, 31, 255, 32'hFFFF_FFFF, 1);
        send_item(4'hF, 0, 0, 32'h0, 1);
        drain();

        // Fill every store the arithmetic reads
        foreach (load_cmds[i]) fill_store(load_cmds[i]);
        drain();

        // Update before any compute sees a zero snapshot
        send_item(elc_pkg::CMD_UPDATE, 31, 255, 32'hFFFF_FFFF, 0);
        send_item(elc_pkg::CMD_RD_STATE, 0, 0, 32'h0, 0);
        send_item(elc_pkg::CMD_RD_STATE, NST-1, CTL-1, 32'h0, 1);
        send_item(elc_pkg::CMD_COMPUTE, 0, 0, 32'h0, 1);
        send_item(elc_pkg::CMD_RD_OUT, 0, 0, 32'h0, 0);
        send_item(elc_pkg::CMD_RD_OUT, NOU-1, CTL-1, 32'h0, 1);
        send_item(elc_pkg::CMD_UPDATE, 0, 0, 32'h0, 1);
        send_item(elc_pkg::CMD_RD_STATE, 1, 17, 32'h0, 1);
        drain();

        // Random mix; the receiver holds off early on to fill the block
        stall_request <= 1'b1;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) drain();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:
                    send_addressed(load_cmds[$urandom_range(0, 4)], 0);
                6, 7:
                    send_addressed(load_cmds[$urandom_range(0, 4)], 1);
                8, 9, 10, 11:
                    send_addressed(elc_pkg::CMD_RD_OUT, ($urandom_range(0, 7) == 0));
                12, 13, 14, 15:
                    send_addressed(elc_pkg::CMD_RD_STATE, ($urandom_range(0, 7) == 0));
                16, 17:
                    send_item(4'($urandom_range(CMD_UNKNOWN_LO, 15)), $urandom_range(0, 31),
                              $urandom_range(0, 255), $urandom(), 1);
                default:
                    if (n_heavy < 4 && $urandom_range(0, 9) == 0) begin
                        n_heavy++;
                        send_item(($urandom_range(0, 1) ? elc_pkg::CMD_COMPUTE
                                                        : elc_pkg::CMD_UPDATE),
                                  $urandom_range(0, 31), $urandom_range(0, 255), $urandom(), 1);
                    end else
                        send_addressed(elc_pkg::CMD_RD_STATE, 0);
            endcase
        end
        drain();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_encrypted_linear_controller_step OK");
        else
            $display("tb_encrypted_linear_controller_step NOT OK");
        $finish;
    end

endmodule
